FILE: src/yrg_pkg.sv
// ----------------------------------------------------------------------------
// yrg_pkg: shared types and constants of the YUY2 to BGR and gray converter
// Holds the BT.601 integer coefficients, the stage enable struct and the
// arithmetic widths used by the chroma unit, the pixel lanes and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package yrg_pkg;

    // Width of the signed products and of the per-channel sums.
    localparam int PROD_W = 19;
    localparam int SUM_W  = 20;

    // BT.601 integer coefficients, all as signed product-width constants.
    localparam logic signed [PROD_W-1:0] COEF_LUMA  = 19'sd298;
    localparam logic signed [PROD_W-1:0] COEF_UB    = 19'sd516;
    localparam logic signed [PROD_W-1:0] COEF_UG    = 19'sd100;
    localparam logic signed [PROD_W-1:0] COEF_VG    = 19'sd208;
    localparam logic signed [PROD_W-1:0] COEF_VR    = 19'sd409;
    localparam logic signed [SUM_W-1:0]  ROUND_HALF = 20'sd128;
    localparam logic [7:0]               LUMA_OFS   = 8'd16;

    // Division by three of a sum of at most 765: multiply by 683, drop 11 bits.
    localparam logic [10:0] GRAY_RECIP = 11'd683;
    localparam int          GRAY_SHIFT = 11;
    localparam int          GRAY_PROD_W = 21;

    // Load enables of the two register stages in front of the output register.
    typedef struct packed {
        logic s1_en;
        logic s2_en;
    } yrg_stage_en_t;

    // Floor the sum by 256 and clamp the result to 0..255.
    function automatic logic [7:0] clamp_shift8(input logic signed [SUM_W-1:0] s);
        logic [7:0] r;
        if (s[SUM_W-1]) begin
            r = 8'd0;
        end else if (|s[SUM_W-2:16]) begin
            r = 8'd255;
        end else begin
            r = s[15:8];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/yrg_chroma.sv
// ----------------------------------------------------------------------------
// yrg_chroma: shared chroma products
// Removes the 128 offset from U and V and registers the blue, green and red
// chroma terms that both pixel lanes add to their luma term.
// ----------------------------------------------------------------------------
`default_nettype none

module yrg_chroma (
    input  wire logic                             aclk,
    input  wire yrg_pkg::yrg_stage_en_t           stage_en,
    input  wire logic [7:0]                       chroma_blue,
    input  wire logic [7:0]                       chroma_red,
    output logic signed [yrg_pkg::PROD_W-1:0]     blue_term_reg,
    output logic signed [yrg_pkg::PROD_W-1:0]     green_term_reg,
    output logic signed [yrg_pkg::PROD_W-1:0]     red_term_reg
);
    import yrg_pkg::*;

    logic signed [PROD_W-1:0] d_ext;
    logic signed [PROD_W-1:0] e_ext;
    logic signed [PROD_W-1:0] blue_term_next;
    logic signed [PROD_W-1:0] green_term_next;
    logic signed [PROD_W-1:0] red_term_next;

    // Flipping the top bit turns an offset-128 byte into its signed value.
    assign d_ext = PROD_W'($signed({~chroma_blue[7], chroma_blue[6:0]}));
    assign e_ext = PROD_W'($signed({~chroma_red[7], chroma_red[6:0]}));

    always_comb begin
        blue_term_next  = d_ext * COEF_UB;
        green_term_next = -(d_ext * COEF_UG) - (e_ext * COEF_VG);
        red_term_next   = e_ext * COEF_VR;
    end

    always_ff @(posedge aclk) begin
        if (stage_en.s1_en) begin
            blue_term_reg  <= blue_term_next;
            green_term_reg <= green_term_next;
            red_term_reg   <= red_term_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/yrg_lane.sv
// ----------------------------------------------------------------------------
// yrg_lane: one pixel lane
// Registers the luma product, then the clamped blue, green and red bytes,
// and gives the pixel's gray value as the truncated mean of those bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module yrg_lane (
    input  wire logic                             aclk,
    input  wire yrg_pkg::yrg_stage_en_t           stage_en,
    input  wire logic [7:0]                       luma,
    input  wire logic signed [yrg_pkg::PROD_W-1:0] blue_term,
    input  wire logic signed [yrg_pkg::PROD_W-1:0] green_term,
    input  wire logic signed [yrg_pkg::PROD_W-1:0] red_term,
    output logic [7:0]                            blue_reg,
    output logic [7:0]                            green_reg,
    output logic [7:0]                            red_reg,
    output logic [7:0]                            gray
);
    import yrg_pkg::*;

    logic signed [PROD_W-1:0] c_ext;
    logic signed [PROD_W-1:0] luma_term_next;
    logic signed [PROD_W-1:0] luma_term_reg;
    logic signed [SUM_W-1:0]  luma_round;
    logic signed [SUM_W-1:0]  blue_sum;
    logic signed [SUM_W-1:0]  green_sum;
    logic signed [SUM_W-1:0]  red_sum;
    logic [7:0]               blue_next;
    logic [7:0]               green_next;
    logic [7:0]               red_next;
    logic [9:0]               chan_sum;
    logic [GRAY_PROD_W-1:0]   gray_prod;

    assign c_ext          = $signed({{(PROD_W-8){1'b0}}, luma})
                          - $signed({{(PROD_W-8){1'b0}}, LUMA_OFS});
    assign luma_term_next = c_ext * COEF_LUMA;

    always_ff @(posedge aclk) begin
        if (stage_en.s1_en) begin
            luma_term_reg <= luma_term_next;
        end
    end

    always_comb begin
        luma_round = SUM_W'(luma_term_reg) + ROUND_HALF;
        blue_sum   = luma_round + SUM_W'(blue_term);
        green_sum  = luma_round + SUM_W'(green_term);
        red_sum    = luma_round + SUM_W'(red_term);
        blue_next  = clamp_shift8(blue_sum);
        green_next = clamp_shift8(green_sum);
        red_next   = clamp_shift8(red_sum);
    end

    always_ff @(posedge aclk) begin
        if (stage_en.s2_en) begin
            blue_reg  <= blue_next;
            green_reg <= green_next;
            red_reg   <= red_next;
        end
    end

    // The mean by three is a reciprocal multiply, exact for every sum up to 765.
    always_comb begin
        chan_sum  = 10'(blue_reg) + 10'(green_reg) + 10'(red_reg);
        gray_prod = GRAY_PROD_W'(chan_sum) * GRAY_PROD_W'(GRAY_RECIP);
        gray      = gray_prod[GRAY_SHIFT+7:GRAY_SHIFT];
    end

endmodule

`default_nettype wire

FILE: src/yuy2_to_rgb_and_gray_top.sv
// ----------------------------------------------------------------------------
// yuy2_to_rgb_and_gray_top: YUY2 macropixel to BGR and gray converter
// Converts each YUY2 macropixel into two BT.601 BGR pixels and their gray
// values with two parallel pixel lanes and a merging output register.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one macropixel per transaction: two luma bytes and
// the shared U and V bytes in s_axis_tdata, with s_axis_tlast marking the final
// macropixel of a frame. The master channel gives one transaction per input:
// both pixels' blue, green and red bytes and their gray bytes in m_axis_tdata,
// and the frame marker copied to m_axis_tlast.
// Throughput is one transaction per clock cycle while the receiver does not
// stall; a result passes three register stages (chroma and luma products,
// clamped channel sums, then gray and the output register).
// Each of the three stages holds its data when the next one is full and
// stalled, so a stall of the receiver fills the stages one by one before
// s_axis_tready falls; no transaction is lost or repeated.
// The block keeps no state between transactions. Reset (aresetn low at a
// clock edge) empties the pipeline; data registers are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module yuy2_to_rgb_and_gray_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Slave channel.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] luma_first, [15:8] chroma_blue, [23:16] luma_second, [31:24] chroma_red
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    // Master channel.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] blue_first, [15:8] green_first, [23:16] red_first,
    // [31:24] blue_second, [39:32] green_second, [47:40] red_second,
    // [55:48] gray_first, [63:56] gray_second
    output logic [63:0]      m_axis_tdata,
    output logic             m_axis_tlast
);
    import yrg_pkg::*;

    // Stage occupancy flags.
    logic s1_valid_reg;
    logic s1_valid_next;
    logic s2_valid_reg;
    logic s2_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    // The frame marker travels alongside the lane data.
    logic s1_last_reg;
    logic s2_last_reg;
    logic out_last_reg;

    // A stage may load when it is empty or its content moves on this cycle.
    logic s1_ready;
    logic s2_ready;
    logic out_ready;

    yrg_stage_en_t stage_en;

    logic signed [PROD_W-1:0] blue_term;
    logic signed [PROD_W-1:0] green_term;
    logic signed [PROD_W-1:0] red_term;

    logic [7:0] blue_a;
    logic [7:0] green_a;
    logic [7:0] red_a;
    logic [7:0] gray_a;
    logic [7:0] blue_b;
    logic [7:0] green_b;
    logic [7:0] red_b;
    logic [7:0] gray_b;

    logic [63:0] out_data_reg;
    logic [63:0] out_data_next;

    assign out_ready = !out_valid_reg || m_axis_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;

    assign stage_en.s1_en = s1_ready;
    assign stage_en.s2_en = s2_ready;

    assign s1_valid_next  = s1_ready  ? s_axis_tvalid : s1_valid_reg;
    assign s2_valid_next  = s2_ready  ? s1_valid_reg  : s2_valid_reg;
    assign out_valid_next = out_ready ? s2_valid_reg  : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_last_reg <= s_axis_tlast;
        end
        if (s2_ready) begin
            s2_last_reg <= s1_last_reg;
        end
        if (out_ready) begin
            out_last_reg <= s2_last_reg;
            out_data_reg <= out_data_next;
        end
    end

    // Chroma products are computed once and shared by both lanes.
    yrg_chroma u_chroma (
        .aclk           (aclk),
        .stage_en       (stage_en),
        .chroma_blue    (s_axis_tdata[15:8]),
        .chroma_red     (s_axis_tdata[31:24]),
        .blue_term_reg  (blue_term),
        .green_term_reg (green_term),
        .red_term_reg   (red_term)
    );

    // Lane for the first pixel of the macropixel.
    yrg_lane u_lane_first (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .luma       (s_axis_tdata[7:0]),
        .blue_term  (blue_term),
        .green_term (green_term),
        .red_term   (red_term),
        .blue_reg   (blue_a),
        .green_reg  (green_a),
        .red_reg    (red_a),
        .gray       (gray_a)
    );

    // Lane for the second pixel of the macropixel.
    yrg_lane u_lane_second (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .luma       (s_axis_tdata[23:16]),
        .blue_term  (blue_term),
        .green_term (green_term),
        .red_term   (red_term),
        .blue_reg   (blue_b),
        .green_reg  (green_b),
        .red_reg    (red_b),
        .gray       (gray_b)
    );

    // Merge both lanes into one output word.
    assign out_data_next = {gray_b, gray_a, red_b, green_b, blue_b, red_a, green_a, blue_a};

    assign s_axis_tready = s1_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: sim/yrg_pixel_checker.sv
// ----------------------------------------------------------------------------
// yrg_pixel_checker: result checker of the YUY2 to BGR and gray converter
// Watches both stream channels of the converter. Every macropixel accepted on
// the slave side is converted here into the two expected BGR pixels and their
// gray values; every transaction on the master side is compared field by
// field with the oldest pending pixel pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module yrg_pixel_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // [7:0] luma_first, [15:8] chroma_blue, [23:16] luma_second, [31:24] chroma_red
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] blue_first, [15:8] green_first, [23:16] red_first,
    // [31:24] blue_second, [39:32] green_second, [47:40] red_second,
    // [55:48] gray_first, [63:56] gray_second
    input  logic [63:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          err_cnt,
    output int          pending_cnt
);

    typedef struct {
        logic [63:0] pixels;
        logic        frame_end;
    } pixel_pair_t;

    pixel_pair_t pixel_pair_q[$];

    string field_names[8] = '{"blue_first", "green_first", "red_first",
                              "blue_second", "green_second", "red_second",
                              "gray_first", "gray_second"};

    // The arithmetic shift of a signed int floors toward minus infinity.
    function automatic logic [7:0] clamp_channel(input int sum);
        int q;
        q = sum >>> 8;
        if (q < 0) begin
            return 8'd0;
        end else if (q > 255) begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

    // Blue, green, red and gray of one pixel, gray in the top byte.
    function automatic logic [31:0] convert_pixel(input logic [7:0] luma,
                                                  input int d, input int e);
        int c;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        int mean;
        c    = int'(luma) - 16;
        b    = clamp_channel(298 * c + 516 * d + 128);
        g    = clamp_channel(298 * c - 100 * d - 208 * e + 128);
        r    = clamp_channel(298 * c + 409 * e + 128);
        mean = (int'(b) + int'(g) + int'(r)) / 3;
        return {mean[7:0], r, g, b};
    endfunction

    function automatic pixel_pair_t convert_macropixel(input logic [31:0] yuyv,
                                                       input logic fin);
        pixel_pair_t res;
        logic [31:0] p0;
        logic [31:0] p1;
        int d;
        int e;
        d  = int'(yuyv[15:8]) - 128;
        e  = int'(yuyv[31:24]) - 128;
        p0 = convert_pixel(yuyv[7:0], d, e);
        p1 = convert_pixel(yuyv[23:16], d, e);
        res.pixels    = {p1[31:24], p0[31:24], p1[23:0], p0[23:0]};
        res.frame_end = fin;
        return res;
    endfunction

    initial begin
        err_cnt     = 0;
        pending_cnt = 0;
    end

    always @(posedge aclk) begin
        pixel_pair_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pixel_pair_q.size() == 0) begin
                    $error("unexpected result transaction, data %h", m_axis_tdata);
                    err_cnt = err_cnt + 1;
                end else begin
                    want = pixel_pair_q.pop_front();
                    for (int i = 0; i < 8; i++) begin
                        if (m_axis_tdata[8*i +: 8] !== want.pixels[8*i +: 8]) begin
                            $error("%s: expected %0d, actual %0d", field_names[i],
                                   want.pixels[8*i +: 8], m_axis_tdata[8*i +: 8]);
                            err_cnt = err_cnt + 1;
                        end
                    end
                    if (m_axis_tlast !== want.frame_end) begin
                        $error("last_out: expected %0d, actual %0d",
                               want.frame_end, m_axis_tlast);
                        err_cnt = err_cnt + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pixel_pair_q.push_back(convert_macropixel(s_axis_tdata, s_axis_tlast));
            end
            pending_cnt <= pixel_pair_q.size();
        end
    end

endmodule

FILE: sim/tb_yuy2_to_rgb_and_gray_top.sv
// ----------------------------------------------------------------------------
// tb_yuy2_to_rgb_and_gray_top: testbench of the YUY2 to BGR and gray converter
// Feeds directed and random YUY2 macropixels in bursts, stalls the result
// channel on a changing pattern and lets a separate checker predict and
// compare every result transaction; the verdict is given here.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_yuy2_to_rgb_and_gray_top;

    // Random macropixels after the directed part.
    localparam int RANDOM_PAIRS = 350;
    // Length of the long receiver hold-off, in cycles.
    localparam int HOLD_CYCLES  = 80;
    // Run limit in clock cycles.
    localparam int CYCLE_LIMIT  = 200000;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [7:0] luma_first, [15:8] chroma_blue, [23:16] luma_second, [31:24] chroma_red
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [7:0] blue_first, [15:8] green_first, [23:16] red_first,
    // [31:24] blue_second, [39:32] green_second, [47:40] red_second,
    // [55:48] gray_first, [63:56] gray_second
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;

    int err_cnt;
    int pending_cnt;
    int cycle_cnt;
    // Raised by the sender to ask the receiver for one long hold-off.
    logic hold_req;

    yuy2_to_rgb_and_gray_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    yrg_pixel_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .err_cnt       (err_cnt),
        .pending_cnt   (pending_cnt)
    );

    // 20 ns clock period.
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Offers one macropixel from a falling edge and returns at the falling
    // edge after the transaction. tready is read at the rising edge, before
    // the block's registers update, exactly as the block sees it.
    task automatic send_macropixel(input logic [7:0] y0, input logic [7:0] u,
                                   input logic [7:0] y1, input logic [7:0] v,
                                   input logic fin);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {v, y1, u, y0};
        s_axis_tlast  = fin;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // Drops tvalid for a number of cycles; the data lines carry noise meanwhile
    // so that a result built from an idle cycle would not match by chance.
    task automatic sender_gap(input int cycles);
        s_axis_tvalid = 1'b0;
        repeat (cycles) begin
            s_axis_tdata = $urandom;
            s_axis_tlast = 1'($urandom_range(0, 1));
            @(negedge aclk);
        end
    endtask

    // Random macropixel: mostly full-range bytes, sometimes luma and chroma
    // kept near the edges of the nominal video range where clamping starts.
    task automatic send_random_pair();
        logic [7:0] y0;
        logic [7:0] u;
        logic [7:0] y1;
        logic [7:0] v;
        if ($urandom_range(0, 3) == 0) begin
            y0 = 8'($urandom_range(0, 1) ? $urandom_range(0, 24) : $urandom_range(228, 255));
            y1 = 8'($urandom_range(0, 1) ? $urandom_range(0, 24) : $urandom_range(228, 255));
            u  = 8'($urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(235, 255));
            v  = 8'($urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(235, 255));
        end else begin
            y0 = 8'($urandom);
            u  = 8'($urandom);
            y1 = 8'($urandom);
            v  = 8'($urandom);
        end
        send_macropixel(y0, u, y1, v, ($urandom_range(0, 15) == 0));
    endtask

    // Receiver: the stall pattern changes every stretch of cycles. One mode
    // never stalls, the others stall at random, periodically or mostly. A
    // request from the sender makes it hold off once, for the length set by HOLD_CYCLES.
    initial begin
        int mode;
        int stretch;
        int phase;
        logic hold_done;
        m_axis_tready = 1'b0;
        phase = 0;
        hold_done = 1'b0;
        @(posedge aresetn);
        forever begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(10, 60);
            repeat (stretch) begin
                @(negedge aclk);
                if (hold_req && !hold_done) begin
                    m_axis_tready = 1'b0;
                    repeat (HOLD_CYCLES - 1) @(negedge aclk);
                    hold_done = 1'b1;
                end else begin
                    phase++;
                    case (mode)
                        0: begin
                            m_axis_tready = 1'b1;
                        end
                        1: begin
                            m_axis_tready = 1'($urandom_range(0, 1));
                        end
                        2: begin
                            m_axis_tready = (phase % 3 != 0);
                        end
                        default: begin
                            m_axis_tready = ($urandom_range(0, 5) == 0);
                        end
                    endcase
                end
            end
        end
    end

    // Sender and verdict.
    initial begin
        int burst_left;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        hold_req      = 1'b0;
        aresetn       = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part: extremes of every byte, black and white, pure
        // colors, and sums that go negative or far above 255 before the
        // clamp. Several of them end a frame.
        send_macropixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
        send_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        send_macropixel(8'd16,  8'd128, 8'd16,  8'd128, 1'b0);
        send_macropixel(8'd235, 8'd128, 8'd235, 8'd128, 1'b0);
        send_macropixel(8'd255, 8'd128, 8'd0,   8'd128, 1'b0);
        send_macropixel(8'd0,   8'd128, 8'd255, 8'd128, 1'b1);
        send_macropixel(8'd128, 8'd0,   8'd128, 8'd255, 1'b0);
        send_macropixel(8'd128, 8'd255, 8'd128, 8'd0,   1'b0);
        send_macropixel(8'd81,  8'd90,  8'd145, 8'd240, 1'b0);
        send_macropixel(8'd145, 8'd54,  8'd210, 8'd34,  1'b0);
        send_macropixel(8'd41,  8'd240, 8'd81,  8'd110, 1'b0);
        send_macropixel(8'd17,  8'd128, 8'd234, 8'd128, 1'b0);
        send_macropixel(8'd255, 8'd0,   8'd0,   8'd255, 1'b0);
        send_macropixel(8'd0,   8'd255, 8'd255, 8'd0,   1'b1);
        send_macropixel(8'd100, 8'd200, 8'd60,  8'd20,  1'b0);
        send_macropixel(8'd200, 8'd30,  8'd90,  8'd220, 1'b1);

        // Let the pipeline drain completely before the random part.
        s_axis_tvalid = 1'b0;
        wait (pending_cnt == 0);
        @(negedge aclk);

        burst_left = 0;
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n == 150) begin
                // Long receiver hold-off while the sender keeps offering
                // back to back: the stages fill and s_axis_tready falls.
                hold_req = 1'b1;
                repeat (40) send_random_pair();
                burst_left = 0;
            end
            if (n == 300) begin
                // Sender pause until every expected result has come out.
                s_axis_tvalid = 1'b0;
                wait (pending_cnt == 0);
                @(negedge aclk);
            end
            if (burst_left == 0) begin
                // Zero-length gaps give stretches without sender idling.
                sender_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 6));
                burst_left = $urandom_range(1, 20);
            end
            send_random_pair();
            burst_left--;
        end
        s_axis_tvalid = 1'b0;

        // Wait for the last results, then a few cycles for any stray one.
        wait (pending_cnt == 0);
        repeat (8) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/yrg_pkg.sv
src/yrg_chroma.sv
src/yrg_lane.sv
src/yuy2_to_rgb_and_gray_top.sv
sim/yrg_pixel_checker.sv
sim/tb_yuy2_to_rgb_and_gray_top.sv
